// File: hdl/weighted_collocation_index_defines.svh
// Assertion macros for the weighted collocation index block.
// Used by the top level; expects clk and arst_n in scope.
`ifndef WEIGHTED_COLLOCATION_INDEX_DEFINES_SVH
`define WEIGHTED_COLLOCATION_INDEX_DEFINES_SVH

// same-cycle implication
`define WCI_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("weighted_collocation_index: assertion failed");

// next-cycle implication
`define WCI_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("weighted_collocation_index: assertion failed");

`endif

// File: hdl/wci_pkg.sv
// Shared types and constants of the weighted collocation index block.
// No dependencies.
`default_nettype none

package wci_pkg;

	localparam int MAX_SAMPLES = 4096;
	localparam int VAL_W       = 16;
	localparam int MAG_W       = 15;
	localparam int CNT_W       = 13;
	localparam int SUM_W       = 60;
	localparam int HALF_W      = 30;
	localparam int PROD_W      = 60;
	localparam int P_W         = 120;
	localparam int R_W         = 150;
	localparam int QP_W        = 136;
	localparam int WIDE_W      = 152;
	localparam int Q_W         = 16;
	localparam int SH_W        = 7;

	localparam logic [MAG_W-1:0] UNIT_WEIGHT = 15'd256;
	localparam logic [Q_W-1:0]   INDEX_MAX   = 16'd32768;

	typedef enum logic [12:0] {
		ST_IDLE = 13'b0000000000001,
		ST_MW1  = 13'b0000000000010,
		ST_MW2  = 13'b0000000000100,
		ST_MX   = 13'b0000000001000,
		ST_MS1  = 13'b0000000010000,
		ST_MS2  = 13'b0000000100000,
		ST_MACC = 13'b0000001000000,
		ST_CHK  = 13'b0000010000000,
		ST_FIN  = 13'b0000100000000,
		ST_SX1  = 13'b0001000000000,
		ST_SX2  = 13'b0010000000000,
		ST_SX3  = 13'b0100000000000,
		ST_OUT  = 13'b1000000000000
	} state_t;

	typedef struct packed {
		logic [HALF_W-1:0] mul_a;
		logic [HALF_W-1:0] mul_b;
		logic [WIDE_W-1:0] add_a;
		logic [WIDE_W-1:0] add_b;
	} unit_op_t;

endpackage

`default_nettype wire

// File: hdl/weighted_collocation_index.sv
// Top level of the weighted collocation index block: stream ports, sequencer, sums.
// A usable sample is accepted and then runs 6 multiply/accumulate steps; a skipped
// sample is not accumulated. After the last sample come check, 8 product steps for
// z11*z22 and z12^2, a 16-bit shift-add search through SX1, SX2 and SX3 per bit, and output;
// only check and output when the index is undefined. A full output register stalls it.
// arst_n low clears the sequencer, sums, count, overflow mark, output valid and config.
// Depends on wci_pkg, wci_unit and weighted_collocation_index_defines.svh.
`default_nettype none

`include "weighted_collocation_index_defines.svh"

module weighted_collocation_index (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_data,   // weight_enable
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,    // value_first, value_second, sample_weight
	input  wire logic [4:0]  s_tuser,    // sample_active, first_defined, second_defined,
	                                     // weight_defined, coords_defined
	input  wire logic        s_tlast,    // last_sample
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,    // index_value, used_count, 3 zero bits
	output logic [1:0]       m_tuser     // index_defined, overflowed
);

	wci_pkg::state_t state_q;

	logic weight_en_q;
	logic [wci_pkg::MAG_W-1:0]  v1_q, v2_q, w_q;
	logic                       last_q;
	logic [wci_pkg::HALF_W-1:0] m1_q, m2_q;
	logic [wci_pkg::SUM_W-1:0]  cross_q, sq1_q, sq2_q;
	logic [wci_pkg::CNT_W-1:0]  cnt_q;
	logic                       ovf_q;
	logic [wci_pkg::P_W-1:0]    p_q;
	logic [wci_pkg::R_W-1:0]    r_q;
	logic [wci_pkg::WIDE_W-1:0] q2p_q, t_q;
	logic [wci_pkg::QP_W-1:0]   qp_q;
	logic [wci_pkg::Q_W-1:0]    q_q;
	logic                       def_q;
	logic [2:0]                 step_q;
	logic [3:0]                 bit_q;

	logic                       m_tvalid_q;
	logic [wci_pkg::Q_W-1:0]    out_idx_q;
	logic [wci_pkg::CNT_W-1:0]  out_cnt_q;
	logic                       out_def_q, out_ovf_q;

	wci_pkg::unit_op_t          op;
	logic [wci_pkg::PROD_W-1:0] mul_q;
	logic [wci_pkg::WIDE_W-1:0] sum;
	logic [wci_pkg::SH_W-1:0]   fin_sh;
	logic                       s_fire, usable, room, le, out_free;
	logic [wci_pkg::Q_W-1:0]    cand;
	logic [wci_pkg::VAL_W-1:0]  in_v1, in_v2, in_w;

	assign in_v1 = s_tdata[15:0];
	assign in_v2 = s_tdata[31:16];
	assign in_w  = s_tdata[47:32];

	assign s_tready = (state_q == wci_pkg::ST_IDLE);
	assign s_fire   = s_tvalid && s_tready;
	assign usable   = s_tuser[0] && s_tuser[1] && !in_v1[15] && s_tuser[2] && !in_v2[15]
		&& (!weight_en_q || (s_tuser[3] && !in_w[15])) && s_tuser[4];
	assign room     = cnt_q < wci_pkg::CNT_W'(wci_pkg::MAX_SAMPLES);
	assign le       = t_q <= wci_pkg::WIDE_W'(r_q);
	assign cand     = q_q | (wci_pkg::Q_W'(1) << bit_q);
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		unique case (step_q)
			3'd1:    fin_sh = 7'd0;
			3'd2:    fin_sh = 7'd30;
			3'd3:    fin_sh = 7'd30;
			3'd4:    fin_sh = 7'd60;
			3'd5:    fin_sh = 7'd30;
			3'd6:    fin_sh = 7'd61;
			3'd7:    fin_sh = 7'd90;
			default: fin_sh = 7'd0;
		endcase
	end

	always_comb begin
		op = '0;
		unique case (state_q)
			wci_pkg::ST_MW1: begin
				op.mul_a = wci_pkg::HALF_W'(w_q);
				op.mul_b = wci_pkg::HALF_W'(v1_q);
			end
			wci_pkg::ST_MW2: begin
				op.mul_a = wci_pkg::HALF_W'(w_q);
				op.mul_b = wci_pkg::HALF_W'(v2_q);
			end
			wci_pkg::ST_MX: begin
				op.mul_a = m1_q;
				op.mul_b = wci_pkg::HALF_W'(v2_q);
			end
			wci_pkg::ST_MS1: begin
				op.mul_a = m1_q;
				op.mul_b = wci_pkg::HALF_W'(v1_q);
				op.add_a = wci_pkg::WIDE_W'(cross_q);
				op.add_b = wci_pkg::WIDE_W'(mul_q);
			end
			wci_pkg::ST_MS2: begin
				op.mul_a = m2_q;
				op.mul_b = wci_pkg::HALF_W'(v2_q);
				op.add_a = wci_pkg::WIDE_W'(sq1_q);
				op.add_b = wci_pkg::WIDE_W'(mul_q);
			end
			wci_pkg::ST_MACC: begin
				op.add_a = wci_pkg::WIDE_W'(sq2_q);
				op.add_b = wci_pkg::WIDE_W'(mul_q);
			end
			wci_pkg::ST_FIN: begin
				unique case (step_q)
					3'd0: begin op.mul_a = sq1_q[29:0];  op.mul_b = sq2_q[29:0];  end
					3'd1: begin op.mul_a = sq1_q[29:0];  op.mul_b = sq2_q[59:30]; end
					3'd2: begin op.mul_a = sq1_q[59:30]; op.mul_b = sq2_q[29:0];  end
					3'd3: begin op.mul_a = sq1_q[59:30]; op.mul_b = sq2_q[59:30]; end
					3'd4: begin op.mul_a = cross_q[29:0];  op.mul_b = cross_q[29:0];  end
					3'd5: begin op.mul_a = cross_q[29:0];  op.mul_b = cross_q[59:30]; end
					3'd6: begin op.mul_a = cross_q[59:30]; op.mul_b = cross_q[59:30]; end
					default: begin op.mul_a = '0; op.mul_b = '0; end
				endcase
				op.add_a = (step_q >= 3'd5) ? wci_pkg::WIDE_W'(r_q) : wci_pkg::WIDE_W'(p_q);
				op.add_b = (step_q == 3'd0) ? '0 : (wci_pkg::WIDE_W'(mul_q) << fin_sh);
			end
			wci_pkg::ST_SX1: begin
				op.add_a = q2p_q;
				op.add_b = wci_pkg::WIDE_W'(qp_q) << ({1'b0, bit_q} + 5'd1);
			end
			wci_pkg::ST_SX2: begin
				op.add_a = t_q;
				op.add_b = wci_pkg::WIDE_W'(p_q) << {bit_q, 1'b0};
			end
			wci_pkg::ST_SX3: begin
				op.add_a = wci_pkg::WIDE_W'(qp_q);
				op.add_b = wci_pkg::WIDE_W'(p_q) << bit_q;
			end
			default: op = '0;
		endcase
	end

	wci_unit u_unit (
		.clk   (clk),
		.op    (op),
		.mul_q (mul_q),
		.sum   (sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_en_q <= 1'b0;
		end else if (cfg_we) begin
			weight_en_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			v1_q   <= in_v1[14:0];
			v2_q   <= in_v2[14:0];
			w_q    <= weight_en_q ? in_w[14:0] : wci_pkg::UNIT_WEIGHT;
			last_q <= s_tlast;
		end
		if (state_q == wci_pkg::ST_MW2) m1_q <= mul_q[29:0];
		if (state_q == wci_pkg::ST_MX)  m2_q <= mul_q[29:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= wci_pkg::ST_IDLE;
			cross_q    <= '0;
			sq1_q      <= '0;
			sq2_q      <= '0;
			cnt_q      <= '0;
			ovf_q      <= 1'b0;
			p_q        <= '0;
			r_q        <= '0;
			q2p_q      <= '0;
			t_q        <= '0;
			qp_q       <= '0;
			q_q        <= '0;
			def_q      <= 1'b0;
			step_q     <= '0;
			bit_q      <= '0;
			m_tvalid_q <= 1'b0;
			out_idx_q  <= '0;
			out_cnt_q  <= '0;
			out_def_q  <= 1'b0;
			out_ovf_q  <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != wci_pkg::ST_OUT) m_tvalid_q <= 1'b0;
			unique case (state_q)
				wci_pkg::ST_IDLE: begin
					if (s_fire) begin
						if (usable && room) begin
							state_q <= wci_pkg::ST_MW1;
						end else begin
							if (usable) ovf_q <= 1'b1;
							if (s_tlast) state_q <= wci_pkg::ST_CHK;
						end
					end
				end
				wci_pkg::ST_MW1: state_q <= wci_pkg::ST_MW2;
				wci_pkg::ST_MW2: state_q <= wci_pkg::ST_MX;
				wci_pkg::ST_MX:  state_q <= wci_pkg::ST_MS1;
				wci_pkg::ST_MS1: begin
					cross_q <= sum[59:0];
					state_q <= wci_pkg::ST_MS2;
				end
				wci_pkg::ST_MS2: begin
					sq1_q   <= sum[59:0];
					state_q <= wci_pkg::ST_MACC;
				end
				wci_pkg::ST_MACC: begin
					sq2_q   <= sum[59:0];
					cnt_q   <= cnt_q + 13'd1;
					state_q <= last_q ? wci_pkg::ST_CHK : wci_pkg::ST_IDLE;
				end
				wci_pkg::ST_CHK: begin
					q_q    <= '0;
					p_q    <= '0;
					r_q    <= '0;
					step_q <= '0;
					if (cnt_q != '0 && sq1_q != '0 && sq2_q != '0) begin
						def_q   <= 1'b1;
						state_q <= wci_pkg::ST_FIN;
					end else begin
						def_q   <= 1'b0;
						state_q <= wci_pkg::ST_OUT;
					end
				end
				wci_pkg::ST_FIN: begin
					if (step_q >= 3'd5) r_q <= sum[149:0];
					else                p_q <= sum[119:0];
					step_q <= step_q + 3'd1;
					if (step_q == 3'd7) begin
						q2p_q   <= '0;
						qp_q    <= '0;
						bit_q   <= 4'd15;
						state_q <= wci_pkg::ST_SX1;
					end
				end
				wci_pkg::ST_SX1: begin
					t_q     <= sum;
					state_q <= wci_pkg::ST_SX2;
				end
				wci_pkg::ST_SX2: begin
					t_q     <= sum;
					state_q <= wci_pkg::ST_SX3;
				end
				wci_pkg::ST_SX3: begin
					if (le) begin
						q2p_q <= t_q;
						qp_q  <= sum[135:0];
						q_q   <= cand;
					end
					if (bit_q == 4'd0) begin
						state_q <= wci_pkg::ST_OUT;
					end else begin
						bit_q   <= bit_q - 4'd1;
						state_q <= wci_pkg::ST_SX1;
					end
				end
				wci_pkg::ST_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						out_idx_q  <= (q_q > wci_pkg::INDEX_MAX) ? wci_pkg::INDEX_MAX : q_q;
						out_def_q  <= def_q;
						out_cnt_q  <= cnt_q;
						out_ovf_q  <= ovf_q;
						cross_q    <= '0;
						sq1_q      <= '0;
						sq2_q      <= '0;
						cnt_q      <= '0;
						ovf_q      <= 1'b0;
						state_q    <= wci_pkg::ST_IDLE;
					end
				end
				default: state_q <= wci_pkg::ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'd0, out_cnt_q, out_idx_q};
	assign m_tuser  = {out_ovf_q, out_def_q};

	`WCI_ASSERT_IMP(a_cnt_cap, 1'b1, cnt_q <= wci_pkg::CNT_W'(wci_pkg::MAX_SAMPLES))
	`WCI_ASSERT_NXT(a_last_blocks, s_tvalid && s_tready && s_tlast, !s_tready)
	`WCI_ASSERT_IMP(a_undef_zero, m_tvalid && !m_tuser[0], m_tdata[15:0] == 16'd0)
	`WCI_ASSERT_NXT(a_bit_step, state_q == wci_pkg::ST_SX3 && bit_q != 4'd0,
		bit_q == $past(bit_q) - 4'd1)

endmodule

`default_nettype wire

// File: hdl/wci_unit.sv
// Shared arithmetic unit: registered 30x30 multiplier and a 152-bit adder.
// Depends on wci_pkg.
`default_nettype none

module wci_unit (
	input  wire logic                        clk,
	input  wire wci_pkg::unit_op_t           op,
	output logic [wci_pkg::PROD_W-1:0]       mul_q,
	output logic [wci_pkg::WIDE_W-1:0]       sum
);

	logic [wci_pkg::PROD_W-1:0] prod;

	assign prod = op.mul_a * op.mul_b;
	assign sum  = op.add_a + op.add_b;

	always_ff @(posedge clk) begin
		mul_q <= prod;
	end

endmodule

`default_nettype wire
